>>> design/tcc_pkg.sv
package tcc_pkg;

    // fixed field widths of the stream words
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CIDX_W = 11;
    localparam int IDX_W  = 12;   // cell index plus one bit, holds any cell count
    localparam int CELL_W = 16;   // character in the low byte, attribute in the high byte
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // character codes and cell constants
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // tab stops every four columns
    localparam logic [COL_W:0] TAB_STEP = (COL_W + 1)'(4);
    localparam logic [COL_W:0] TAB_MASK = ~(TAB_STEP - (COL_W + 1)'(1));

    // operation codes
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } tcc_op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;       // input word accepted this cycle
        logic copy;       // one step of the scroll copy
        logic fill;       // write one blank cell
        logic fill_init;  // blank with the reset attribute
        logic load_out;   // load the result register
    } tcc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        tcc_op_t op;         // operation of the word on the input
        logic    scroll;     // a put on the input would scroll
        logic    copy_done;  // all rows moved up
        logic    fill_last;  // last cell of the fill range
    } tcc_stat_t;

endpackage

>>> design/tcc_ram.sv
module tcc_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 2000,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/tcc_ctrl.sv
module tcc_ctrl
    import tcc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  tcc_stat_t stat,
    output tcc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;

    // take a word only when idle and the result register is free by the next edge
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.fill      = 1'b1;
                cmd.fill_init = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.take = 1'b1;
                    if (stat.op == OP_PUT && stat.scroll) begin
                        state_next = ST_COPY;
                    end else if (stat.op == OP_CLEAR) begin
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_COPY: begin
                cmd.copy = 1'b1;
                if (stat.copy_done) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.load_out = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> design/tcc_dp.sv
module tcc_dp
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tcc_cmd_t            cmd,
    output tcc_stat_t           stat,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);

    // input word fields
    tcc_op_t           op;
    logic [7:0]        ch;
    logic [CIDX_W-1:0] cidx;
    logic [IDX_W-1:0]  cidx_ext;
    logic              cidx_ok;

    assign op       = tcc_op_t'(s_tdata[1:0]);
    assign ch       = s_tdata[9:2];
    assign cidx     = s_tdata[20:10];
    assign cidx_ext = {1'b0, cidx};
    assign cidx_ok  = cidx_ext < IDX_W'(CELL_COUNT);

    // state
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [7:0]        attr_reg;
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [ADDR_W-1:0] fill_cnt_reg;
    logic              scrolled_reg;
    logic              rd_ok_reg;
    logic [M_DATA_W-1:0] out_reg;

    // ram port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // cursor step for a put
    logic [COL_W:0]    col_step;
    logic [ROW_W:0]    row_step;
    logic [COL_W-1:0]  col_fin;
    logic [ROW_W-1:0]  row_fin;
    logic              put_scroll;
    logic              put_store;
    logic [ADDR_W-1:0] put_addr;

    always_comb begin
        col_step   = {1'b0, col_reg};
        row_step   = {1'b0, row_reg};
        put_scroll = 1'b0;
        if (ch == CH_NEWLINE) begin
            col_step = '0;
            row_step = row_step + (ROW_W + 1)'(1);
        end else if (ch == CH_TAB) begin
            col_step = (col_step + TAB_STEP) & TAB_MASK;
        end else begin
            col_step = col_step + (COL_W + 1)'(1);
        end
        // wrap past the last column
        if (col_step >= (COL_W + 1)'(COLUMNS)) begin
            col_step = '0;
            row_step = row_step + (ROW_W + 1)'(1);
        end
        // scroll past the last row
        if (row_step >= (ROW_W + 1)'(ROWS)) begin
            row_step   = (ROW_W + 1)'(ROWS - 1);
            put_scroll = 1'b1;
        end
        col_fin = col_step[COL_W-1:0];
        row_fin = row_step[ROW_W-1:0];
    end

    assign put_store = (ch != CH_NEWLINE) && (ch != CH_TAB);
    assign put_addr  = ADDR_W'(row_reg * COLUMNS + col_reg);

    // scroll copy: read a cell of a row below, write it back one row up in the cycle after
    logic copy_issue;
    assign copy_issue = rd_cnt_reg < CNT_W'(CELL_COUNT);

    // status
    always_comb begin
        stat.op        = op;
        stat.scroll    = put_scroll;
        stat.copy_done = (rd_cnt_reg == CNT_W'(CELL_COUNT)) && !pend_reg;
        stat.fill_last = fill_cnt_reg == ADDR_W'(CELL_COUNT - 1);
    end

    // memory port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (cmd.take) begin
            ram_we    = (op == OP_PUT) && put_store;
            ram_waddr = put_addr;
            ram_wdata = {attr_reg, ch};
            ram_re    = (op == OP_READ) && cidx_ok;
            ram_raddr = cidx_ext[ADDR_W-1:0];
        end else if (cmd.copy) begin
            ram_we    = pend_reg;
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata;
            ram_re    = copy_issue;
            ram_raddr = rd_cnt_reg[ADDR_W-1:0];
        end else if (cmd.fill) begin
            ram_we    = 1'b1;
            ram_waddr = fill_cnt_reg;
            ram_wdata = {(cmd.fill_init ? ATTR_RESET : attr_reg), CH_SPACE};
        end
    end

    tcc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // cursor, attribute and sweep counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            attr_reg     <= ATTR_RESET;
            rd_cnt_reg   <= CNT_W'(CELL_COUNT);
            pend_reg     <= 1'b0;
            fill_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                attr_reg <= cfg_data;
            end
            if (cmd.take) begin
                if (op == OP_PUT) begin
                    col_reg <= col_fin;
                    row_reg <= row_fin;
                end else if (op == OP_CLEAR) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                rd_cnt_reg   <= CNT_W'(COLUMNS);
                pend_reg     <= 1'b0;
                fill_cnt_reg <= (op == OP_CLEAR) ? '0 : ADDR_W'(CELL_COUNT - COLUMNS);
            end else if (cmd.copy) begin
                if (copy_issue) begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
                pend_reg <= copy_issue;
            end else if (cmd.fill) begin
                fill_cnt_reg <= fill_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // per-word flags and result register
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            scrolled_reg <= (op == OP_PUT) && put_scroll;
            rd_ok_reg    <= (op == OP_READ) && cidx_ok;
        end
        if (cmd.copy) begin
            wr_addr_reg <= ADDR_W'(rd_cnt_reg - CNT_W'(COLUMNS));
        end
        if (cmd.load_out) begin
            out_reg <= {3'b000,
                        (rd_ok_reg ? ram_rdata[15:8] : 8'h00),
                        (rd_ok_reg ? ram_rdata[7:0] : 8'h00),
                        scrolled_reg, row_reg, col_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

>>> design/text_console_cursor_scroll.sv
// Text console with a screen store of COLUMNS x ROWS cells (character in the
// low byte, attribute in the high byte) and a cursor. A put that does not
// scroll, a read and an unused op code each pass from acceptance through the
// DONE state to the result register; the screen memory has one write and one
// registered read port. A clear writes every cell once; a put that scrolls
// copies every row but the top one through the same memory port and then
// blanks the bottom row. After reset a clearing pass over all COLUMNS*ROWS
// cells (2000 at the default size) fills the screen with spaces in attribute
// 0x0F; no word is accepted until it ends, while attribute writes on the cfg
// channel are taken at any time.
module text_console_cursor_scroll
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // op[1:0], char_code[9:2], cell_index[20:10]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // cursor_col[6:0], cursor_row[11:7], scrolled[12],
                                           // cell_char[20:13], cell_attr[28:21]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data   // text_attribute
);

    tcc_cmd_t  cmd;
    tcc_stat_t stat;

    // attribute register is always writable
    assign cfg_ready = 1'b1;

    tcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcc_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata)
    );

    // one word in flight at a time
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while one is in progress");

    // a read returns its word through the done state, with no copy or fill
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[1:0] == OP_READ) |=> ##1 m_tvalid)
        else $error("read result late");

    // controller issues at most one command per cycle
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.take, cmd.copy, cmd.fill, cmd.load_out}))
        else $error("overlapping datapath commands");

    // reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] < 7'(COLUMNS)) && (m_tdata[11:7] < 5'(ROWS)))
        else $error("cursor off screen");

endmodule

>>> tb/console_screen_checker.sv
module console_screen_checker
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // op[1:0], char_code[9:2], cell_index[20:10]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // cursor_col[6:0], cursor_row[11:7], scrolled[12],
                                           // cell_char[20:13], cell_attr[28:21]
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    output int                  fail_count,
    output int                  expected_left,
    output int                  checked_count,
    output int                  scroll_count,
    output int                  clear_count
);

    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int TAB_STOP    = 4;
    localparam int REPORT_MAX  = 10;
    localparam int RESULT_BITS = COL_W + ROW_W + 1 + 8 + 8;

    // result word, lowest field last so that it lines up with m_tdata
    typedef struct packed {
        logic [7:0]       attr;
        logic [7:0]       ch;
        logic             scrolled;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } console_result_t;

    // own copy of the screen, the cursor and the attribute
    logic [CELL_W-1:0] screen_cells [CELL_COUNT];
    int                cur_col;
    int                cur_row;
    logic [7:0]        text_attr;
    console_result_t   expected_words [$];
    int                fails;
    int                checked;
    int                scrolls;
    int                clears;

    function automatic logic [CELL_W-1:0] blank_cell(logic [7:0] attr);
        return {attr, CH_SPACE};
    endfunction

    // works out the result of one input word and moves the screen on
    function automatic console_result_t predict_console_word(logic [1:0] op, logic [7:0] ch,
                                                             logic [CIDX_W-1:0] idx);
        console_result_t r;
        r = '0;
        case (op)
            OP_PUT: begin
                if (ch == CH_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (ch == CH_TAB) begin
                    cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
                end else begin
                    screen_cells[cur_row * COLUMNS + cur_col] = {text_attr, ch};
                    cur_col++;
                end
                // wrap at the end of a line
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // off the bottom: move every row up and blank the last one
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                        screen_cells[i] = screen_cells[i + COLUMNS];
                    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        screen_cells[i] = blank_cell(text_attr);
                    cur_row    = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++)
                    screen_cells[i] = blank_cell(text_attr);
                cur_col = 0;
                cur_row = 0;
            end
            OP_READ: begin
                if (idx < CELL_COUNT)
                    {r.attr, r.ch} = screen_cells[idx];
            end
            default: begin
                // unused code leaves everything as it is
            end
        endcase
        r.col = COL_W'(cur_col);
        r.row = ROW_W'(cur_row);
        return r;
    endfunction

    // watch the three channels, predict on input words, compare on result words
    always @(posedge aclk) begin
        console_result_t got;
        console_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen_cells[i] = blank_cell(ATTR_RESET);
            cur_col   = 0;
            cur_row   = 0;
            text_attr = ATTR_RESET;
            expected_words.delete();
            fails   = 0;
            checked = 0;
            scrolls = 0;
            clears  = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                text_attr = cfg_data;
            if (s_tvalid && s_tready) begin
                want = predict_console_word(s_tdata[1:0], s_tdata[9:2], s_tdata[20:10]);
                if (want.scrolled)
                    scrolls++;
                if (s_tdata[1:0] == OP_CLEAR)
                    clears++;
                expected_words.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_BITS-1:0];
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("unexpected result word %08h with nothing outstanding", m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    checked++;
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display("result %0d mismatch", checked);
                            $display("  want col %0d row %0d scr %0b char %02h attr %02h",
                                     want.col, want.row, want.scrolled, want.ch, want.attr);
                            $display("  got  col %0d row %0d scr %0b char %02h attr %02h",
                                     got.col, got.row, got.scrolled, got.ch, got.attr);
                        end
                    end
                end
            end
        end
        fail_count    <= fails;
        expected_left <= expected_words.size();
        checked_count <= checked;
        scroll_count  <= scrolls;
        clear_count   <= clears;
    end

endmodule

>>> tb/text_console_cursor_scroll_tb.sv
module text_console_cursor_scroll_tb;
    import tcc_pkg::*;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELL_COUNT    = COLUMNS * ROWS;
    localparam int IDX_MAX       = 2 ** CIDX_W - 1;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int PHASE_ITEMS   = 200;
    localparam int GAP_MAX       = 11;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 10;

    // op code that the block leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // op[1:0], char_code[9:2], cell_index[20:10]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // cursor_col[6:0], cursor_row[11:7], scrolled[12],
                                           // cell_char[20:13], cell_attr[28:21]
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_data  = '0;

    int fail_count;
    int expected_left;
    int checked_count;
    int scroll_count;
    int clear_count;
    int words_sent;
    int attr_writes;
    int quiet_cycles;
    bit steady;

    text_console_cursor_scroll #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    console_screen_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) screen_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .expected_left (expected_left),
        .checked_count (checked_count),
        .scroll_count  (scroll_count),
        .clear_count   (clear_count)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // reset at the start of the run only
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall before each word, none in steady stretches
    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, GAP_MAX);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // one input word, after a random gap
    task automatic send_word(logic [1:0] op, logic [7:0] ch, logic [CIDX_W-1:0] idx);
        int gap;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_DATA_W'({idx, ch, op});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        words_sent++;
    endtask

    // hold the input until every outstanding result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
    endtask

    task automatic write_attribute(logic [7:0] attr);
        cfg_data  <= attr;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        attr_writes++;
    endtask

    function automatic logic [CIDX_W-1:0] pick_cell();
        if ($urandom_range(0, 7) == 0)
            return CIDX_W'($urandom_range(CELL_COUNT, IDX_MAX));
        return CIDX_W'($urandom_range(0, CELL_COUNT - 1));
    endfunction

    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(0, 15))
            0:       return CH_NEWLINE;
            1:       return CH_TAB;
            2, 3:    return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    // one random run of words: text, tabs, newlines, reads, a clear or noise
    task automatic send_random_run();
        int kind;
        int len;
        kind   = $urandom_range(0, 19);
        steady = ($urandom_range(0, 4) == 0);
        if (kind <= 8) begin
            len = $urandom_range(1, 60);
            repeat (len) send_word(OP_PUT, pick_text_char(), CIDX_W'($urandom));
        end else if (kind <= 10) begin
            len = $urandom_range(1, 24);
            repeat (len) send_word(OP_PUT, CH_TAB, CIDX_W'($urandom));
        end else if (kind <= 12) begin
            len = $urandom_range(1, 4);
            repeat (len) send_word(OP_PUT, CH_NEWLINE, CIDX_W'($urandom));
        end else if (kind <= 15) begin
            len = $urandom_range(1, 8);
            repeat (len) send_word(OP_READ, 8'($urandom), pick_cell());
        end else if (kind == 16) begin
            send_word(OP_CLEAR, 8'($urandom), CIDX_W'($urandom));
        end else begin
            len = $urandom_range(1, 4);
            repeat (len) send_word(2'($urandom_range(0, 3)), 8'($urandom), CIDX_W'($urandom));
        end
    endtask

    // stimulus and verdict
    initial begin
        int phase;
        int phase_end;
        int random_end;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // directed: reset screen, field extremes, every op, with the reset attribute
        send_word(OP_READ, 8'h00, '0);
        send_word(OP_READ, 8'hFF, CIDX_W'(CELL_COUNT - 1));
        send_word(OP_READ, 8'h00, CIDX_W'(CELL_COUNT));
        send_word(OP_READ, 8'h00, CIDX_W'(IDX_MAX));
        send_word(OP_UNUSED, 8'hFF, CIDX_W'(IDX_MAX));
        send_word(OP_PUT, 8'h41, '0);
        send_word(OP_PUT, 8'h00, CIDX_W'(IDX_MAX));
        send_word(OP_PUT, 8'hFF, '0);
        send_word(OP_PUT, CH_TAB, '0);
        send_word(OP_PUT, 8'h7E, '0);
        send_word(OP_PUT, CH_NEWLINE, '0);
        send_word(OP_READ, 8'h00, CIDX_W'(0));
        send_word(OP_READ, 8'h00, CIDX_W'(2));
        send_word(OP_READ, 8'h00, CIDX_W'(4));
        send_word(OP_CLEAR, 8'hFF, CIDX_W'(IDX_MAX));
        send_word(OP_READ, 8'h00, CIDX_W'(0));

        // lowest attribute: blanks and writes both take it
        drain_results();
        write_attribute(8'h00);
        send_word(OP_PUT, CH_SPACE, '0);
        send_word(OP_READ, 8'h00, CIDX_W'(0));
        send_word(OP_CLEAR, 8'h00, '0);
        send_word(OP_READ, 8'h00, CIDX_W'(CELL_COUNT - 1));

        // highest attribute
        drain_results();
        write_attribute(8'hFF);
        send_word(OP_PUT, 8'h5A, '0);
        send_word(OP_READ, 8'h00, CIDX_W'(0));
        send_word(OP_CLEAR, 8'h00, '0);
        send_word(OP_READ, 8'h00, CIDX_W'(1000));

        // random phases, each closed by a full drain and a new attribute
        random_end = words_sent + RANDOM_ITEMS;
        phase      = 0;
        while (words_sent < random_end) begin
            phase_end = words_sent + PHASE_ITEMS;
            while (words_sent < phase_end && words_sent < random_end)
                send_random_run();
            steady = 1'b0;
            drain_results();
            case (phase % 4)
                0:       write_attribute(8'h00);
                1:       write_attribute(8'hFF);
                default: write_attribute(8'($urandom_range(0, 255)));
            endcase
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d words over %0d attribute settings, %0d results checked",
                 words_sent, attr_writes + 1, checked_count);
        $display("screen scrolled %0d times and was cleared %0d times",
                 scroll_count, clear_count);
        if (fail_count == 0 && expected_left == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> text_console_cursor_scroll.f
design/tcc_pkg.sv
design/tcc_ram.sv
design/tcc_ctrl.sv
design/tcc_dp.sv
design/text_console_cursor_scroll.sv
tb/console_screen_checker.sv
tb/text_console_cursor_scroll_tb.sv
